// ===== rtl/tccw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console package
// Shared types, sizes and codes of the character-cell text console.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int COLUMNS   = 64;
    localparam int ROWS      = 32;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int COL_FW    = 6;
    localparam int ROW_FW    = 5;
    localparam int REG_COUNT = 3;
    localparam int PADDR_W   = $clog2(4 * REG_COUNT);

    localparam logic [2:0] CMD_PUT   = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_BLINK = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] REG_DEFAULT_COLOR = 2'd0;
    localparam logic [1:0] REG_BLANK_GLYPH   = 2'd1;
    localparam logic [1:0] REG_CURSOR_GLYPH  = 2'd2;

    localparam logic [31:0] RST_DEFAULT_COLOR = 32'h00FF_FFFF;
    localparam logic [7:0]  RST_BLANK_GLYPH   = 8'd32;
    localparam logic [7:0]  RST_CURSOR_GLYPH  = 8'd95;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef logic [CELL_W-1:0] t_addr;
    typedef logic [CELL_W:0]   t_idx;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [7:0]        char_byte;
        logic [31:0]       char_color;
        logic [COL_FW-1:0] col_arg;
        logic [ROW_FW-1:0] row_arg;
    } t_in;

    typedef struct packed {
        logic [7:0]        read_glyph;
        logic [31:0]       read_color;
        logic [COL_FW-1:0] cursor_col_now;
        logic [ROW_FW-1:0] cursor_row_now;
        logic              scrolled;
    } t_out;

    typedef struct packed {
        logic [31:0] default_color;
        logic [7:0]  blank_glyph;
        logic [7:0]  cursor_glyph;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  glyph;
        logic [31:0] color;
    } t_cell;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    function automatic t_addr cell_addr(input logic [COL_FW-1:0] col,
                                        input logic [ROW_FW-1:0] row);
        return t_addr'(row) * t_addr'(COLUMNS) + t_addr'(col);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tccw_cell_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cell memory
// One write port and one registered read port holding glyph and color.
// ----------------------------------------------------------------------------
module tccw_cell_ram (
    input  wire logic              i_clk,
    input  wire tccw_pkg::t_ram_req i_req,
    output tccw_pkg::t_cell         o_rdata
);

    tccw_pkg::t_cell r_mem [tccw_pkg::CELLS];
    tccw_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/tccw_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for the default color and the two glyph codes.
// ----------------------------------------------------------------------------
module tccw_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tccw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output tccw_pkg::t_cfg                    o_cfg
);

    tccw_pkg::t_cfg r_cfg;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[tccw_pkg::PADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_color <= tccw_pkg::RST_DEFAULT_COLOR;
            r_cfg.blank_glyph   <= tccw_pkg::RST_BLANK_GLYPH;
            r_cfg.cursor_glyph  <= tccw_pkg::RST_CURSOR_GLYPH;
        end else if (wr_en) begin
            unique case (reg_index)
                tccw_pkg::REG_DEFAULT_COLOR: r_cfg.default_color <= pwdata;
                tccw_pkg::REG_BLANK_GLYPH:   r_cfg.blank_glyph   <= pwdata[7:0];
                tccw_pkg::REG_CURSOR_GLYPH:  r_cfg.cursor_glyph  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            tccw_pkg::REG_DEFAULT_COLOR: prdata = r_cfg.default_color;
            tccw_pkg::REG_BLANK_GLYPH:   prdata = {24'd0, r_cfg.blank_glyph};
            tccw_pkg::REG_CURSOR_GLYPH:  prdata = {24'd0, r_cfg.cursor_glyph};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/tccw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Console sequencer
// Decodes commands, keeps the cursor and sweeps the cell memory for clear,
// scroll and the post-reset blanking pass.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tccw_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    input  wire tccw_pkg::t_in      i_in_data,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tccw_pkg::t_out          o_out_data,
    output tccw_pkg::t_ram_req      o_ram_req,
    input  wire tccw_pkg::t_cell    i_ram_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_FILL   = 5'b01000,
        ST_WAIT   = 5'b10000
    } t_state;

    localparam tccw_pkg::t_idx SCROLL_LAST =
        tccw_pkg::t_idx'(tccw_pkg::CELLS - tccw_pkg::COLUMNS);
    localparam tccw_pkg::t_idx FILL_LAST = tccw_pkg::t_idx'(tccw_pkg::CELLS - 1);

    t_state                        r_state, n_state;
    logic [tccw_pkg::COL_FW-1:0]   r_col, n_col;
    logic [tccw_pkg::ROW_FW-1:0]   r_row, n_row;
    logic                          r_dq, n_dq;
    logic [7:0]                    r_blink, n_blink;
    tccw_pkg::t_idx                r_idx, n_idx;
    logic [7:0]                    r_fill_glyph, n_fill_glyph;
    logic                          r_has_res, n_has_res;
    tccw_pkg::t_out                r_res, n_res;
    tccw_pkg::t_out                r_out, n_out;
    logic                          r_out_valid, n_out_valid;
    tccw_pkg::t_ram_req            ram_req;
    logic                          accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic [tccw_pkg::COL_FW:0] col_sum;
        logic [tccw_pkg::ROW_FW:0] row_sum;
        logic                      dq_next;
        logic [7:0]                put_glyph;
        tccw_pkg::t_out            res;

        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_dq         = r_dq;
        n_blink      = r_blink;
        n_idx        = r_idx;
        n_fill_glyph = r_fill_glyph;
        n_has_res    = r_has_res;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_req      = '0;
        col_sum      = '0;
        row_sum      = '0;
        dq_next      = r_dq;
        put_glyph    = i_in_data.char_byte;
        res          = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    res.cursor_col_now = r_col;
                    res.cursor_row_now = r_row;
                    n_state            = ST_WAIT;
                    n_has_res          = 1'b1;
                    unique case (i_in_data.cmd)
                        tccw_pkg::CMD_PUT: begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = tccw_pkg::cell_addr(r_col, r_row);
                            row_sum       = {1'b0, r_row};
                            if (i_in_data.char_byte == tccw_pkg::CH_TAB) begin
                                ram_req.wdata.glyph = i_cfg.blank_glyph;
                                ram_req.wdata.color = i_cfg.default_color;
                                col_sum = {1'b0, r_col} + (tccw_pkg::COL_FW + 1)'(2);
                            end else if (i_in_data.char_byte == tccw_pkg::CH_NEWLINE) begin
                                ram_req.wdata.glyph = i_cfg.blank_glyph;
                                ram_req.wdata.color = i_cfg.default_color;
                                col_sum = '0;
                                row_sum = {1'b0, r_row} + (tccw_pkg::ROW_FW + 1)'(1);
                                n_blink = '0;
                            end else begin
                                dq_next = r_dq ^ (i_in_data.char_byte == tccw_pkg::CH_QUOTE);
                                if (!dq_next && i_in_data.char_byte >= tccw_pkg::CH_LOWER_A
                                        && i_in_data.char_byte <= tccw_pkg::CH_LOWER_Z) begin
                                    put_glyph = i_in_data.char_byte - tccw_pkg::CASE_OFFSET;
                                end
                                n_dq = dq_next;
                                ram_req.wdata.glyph = put_glyph;
                                ram_req.wdata.color = i_in_data.char_color;
                                col_sum = {1'b0, r_col} + (tccw_pkg::COL_FW + 1)'(1);
                            end
                            if (col_sum >= (tccw_pkg::COL_FW + 1)'(tccw_pkg::COLUMNS)) begin
                                n_col = tccw_pkg::COL_FW'(tccw_pkg::COLUMNS - 1);
                            end else begin
                                n_col = col_sum[tccw_pkg::COL_FW-1:0];
                            end
                            if (row_sum >= (tccw_pkg::ROW_FW + 1)'(tccw_pkg::ROWS)) begin
                                n_row        = tccw_pkg::ROW_FW'(tccw_pkg::ROWS - 1);
                                res.scrolled = 1'b1;
                                n_idx        = '0;
                                n_state      = ST_SCROLL;
                            end else begin
                                n_row = row_sum[tccw_pkg::ROW_FW-1:0];
                            end
                            res.cursor_col_now = n_col;
                            res.cursor_row_now = n_row;
                        end
                        tccw_pkg::CMD_SET: begin
                            if ({1'b0, i_in_data.col_arg}
                                    >= (tccw_pkg::COL_FW + 1)'(tccw_pkg::COLUMNS)) begin
                                n_col = tccw_pkg::COL_FW'(tccw_pkg::COLUMNS - 1);
                            end else begin
                                n_col = i_in_data.col_arg;
                            end
                            if ({1'b0, i_in_data.row_arg}
                                    >= (tccw_pkg::ROW_FW + 1)'(tccw_pkg::ROWS)) begin
                                n_row = tccw_pkg::ROW_FW'(tccw_pkg::ROWS - 1);
                            end else begin
                                n_row = i_in_data.row_arg;
                            end
                            res.cursor_col_now = n_col;
                            res.cursor_row_now = n_row;
                        end
                        tccw_pkg::CMD_CLEAR: begin
                            n_idx        = '0;
                            n_fill_glyph = i_cfg.blank_glyph;
                            n_state      = ST_FILL;
                        end
                        tccw_pkg::CMD_BLINK: begin
                            ram_req.we          = 1'b1;
                            ram_req.waddr       = tccw_pkg::cell_addr(r_col, r_row);
                            ram_req.wdata.glyph = r_blink[4] ? i_cfg.blank_glyph
                                                             : i_cfg.cursor_glyph;
                            ram_req.wdata.color = i_cfg.default_color;
                            n_blink             = r_blink + 8'd1;
                        end
                        tccw_pkg::CMD_READ: begin
                            if ({1'b0, i_in_data.col_arg}
                                    < (tccw_pkg::COL_FW + 1)'(tccw_pkg::COLUMNS)
                                    && {1'b0, i_in_data.row_arg}
                                    < (tccw_pkg::ROW_FW + 1)'(tccw_pkg::ROWS)) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = tccw_pkg::cell_addr(i_in_data.col_arg,
                                                                    i_in_data.row_arg);
                                n_state       = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res = res;
                end
            end
            ST_READ: begin
                n_res.read_glyph = i_ram_rdata.glyph;
                n_res.read_color = i_ram_rdata.color;
                n_state          = ST_WAIT;
            end
            ST_SCROLL: begin
                if (r_idx != SCROLL_LAST) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_idx[tccw_pkg::CELL_W-1:0]
                                    + tccw_pkg::t_addr'(tccw_pkg::COLUMNS);
                end
                if (r_idx != '0) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_idx[tccw_pkg::CELL_W-1:0] - tccw_pkg::t_addr'(1);
                    ram_req.wdata = i_ram_rdata;
                end
                if (r_idx == SCROLL_LAST) begin
                    n_fill_glyph = i_cfg.blank_glyph;
                    n_state      = ST_FILL;
                end else begin
                    n_idx = r_idx + tccw_pkg::t_idx'(1);
                end
            end
            ST_FILL: begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = r_idx[tccw_pkg::CELL_W-1:0];
                ram_req.wdata.glyph = r_fill_glyph;
                ram_req.wdata.color = '0;
                if (r_idx == FILL_LAST) begin
                    n_state = r_has_res ? ST_WAIT : ST_IDLE;
                end else begin
                    n_idx = r_idx + tccw_pkg::t_idx'(1);
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_has_res   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_col        <= '0;
            r_row        <= '0;
            r_dq         <= 1'b0;
            r_blink      <= '0;
            r_idx        <= '0;
            r_fill_glyph <= tccw_pkg::RST_BLANK_GLYPH;
            r_has_res    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_dq         <= n_dq;
            r_blink      <= n_blink;
            r_idx        <= n_idx;
            r_fill_glyph <= n_fill_glyph;
            r_has_res    <= n_has_res;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_ram_req   = ram_req;

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.re && ram_req.we) |-> (ram_req.raddr > ram_req.waddr))
        else $error("Scroll sweep writes ahead of its read.");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ram_req.re) |=> (r_state == ST_READ))
        else $error("Cell read not followed by its data capture.");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ({1'b0, r_col} < (tccw_pkg::COL_FW + 1)'(tccw_pkg::COLUMNS)
                                  && {1'b0, r_row} < (tccw_pkg::ROW_FW + 1)'(tccw_pkg::ROWS)))
        else $error("Cursor outside the grid.");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && r_out_valid && !i_out_ready) |=> (r_state == ST_WAIT))
        else $error("Pending result dropped while the output is stalled.");

endmodule
`default_nettype wire

// ===== rtl/text_console_char_writer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer
// Character-cell console with a glyph and color grid, cursor and scrolling.
// ----------------------------------------------------------------------------
// Commands enter on the input channel as one beat each and every command
// returns exactly one result beat on the output channel. Configuration is
// to be written through the APB-style port only while the console is idle;
// the block does not enforce this. Put byte without scroll, set cursor,
// blink tick and unknown commands go from acceptance to the wait state and
// then into the output register; a cell read goes through the read state
// first, as the cell memory returns registered data in the cycle after the
// address. Clear walks the whole cell memory one cell a cycle. A put that
// scrolls copies every row up one through the memory read and write ports,
// one cell a cycle, then blanks the bottom row. The input is taken only
// while no command is in progress, so a new command waits until the last
// result is in the output register. After reset the sequencer blanks all
// CELLS cells with the input ready held low; configuration writes are taken
// meanwhile. A finished result waits in the output register while the
// receiver stalls; the next command is accepted and runs, and its result is
// held until the output register frees.
// ----------------------------------------------------------------------------
module text_console_char_writer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire tccw_pkg::t_in                i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tccw_pkg::t_out                    o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tccw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    tccw_pkg::t_cfg     cfg;
    tccw_pkg::t_ram_req ram_req;
    tccw_pkg::t_cell    ram_rdata;

    tccw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tccw_cell_ram u_cell_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== bench/tb_text_console_char_writer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives console commands with random idle gaps on both channels and writes
// the registers between phases. A shadow copy of the cell grid and cursor
// predicts every result beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer_core;

    localparam int N_ITEMS   = 1900;
    localparam int N_PHASES  = 6;
    localparam int HEAVY_MAX = 120;
    localparam int MAX_LINES = 200;
    localparam int unsigned CYCLE_LIMIT =
        4 * (2 * tccw_pkg::CELLS + (N_ITEMS + 100) * 44
             + HEAVY_MAX * (tccw_pkg::CELLS + 4) + N_PHASES * 64);

    class console_grid_model;
        logic [7:0]       glyphs [tccw_pkg::CELLS];
        logic [31:0]      colors [tccw_pkg::CELLS];
        int               cur_col;
        int               cur_row;
        bit               quoted;
        logic [7:0]       blink_ticks;
        tccw_pkg::t_cfg   cfg;
        tccw_pkg::t_out   due_results [$];

        function new();
            cfg.default_color = tccw_pkg::RST_DEFAULT_COLOR;
            cfg.blank_glyph   = tccw_pkg::RST_BLANK_GLYPH;
            cfg.cursor_glyph  = tccw_pkg::RST_CURSOR_GLYPH;
            for (int i = 0; i < tccw_pkg::CELLS; i++) begin
                glyphs[i] = tccw_pkg::RST_BLANK_GLYPH;
                colors[i] = '0;
            end
            cur_col     = 0;
            cur_row     = 0;
            quoted      = 1'b0;
            blink_ticks = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                tccw_pkg::REG_DEFAULT_COLOR: cfg.default_color = value;
                tccw_pkg::REG_BLANK_GLYPH:   cfg.blank_glyph   = value[7:0];
                tccw_pkg::REG_CURSOR_GLYPH:  cfg.cursor_glyph  = value[7:0];
                default: ;
            endcase
        endfunction

        function void store_at_cursor(logic [7:0] glyph, logic [31:0] color);
            int idx;
            idx = cur_row * tccw_pkg::COLUMNS + cur_col;
            if (idx < tccw_pkg::CELLS) begin
                glyphs[idx] = glyph;
                colors[idx] = color;
            end
        endfunction

        function void note_command(tccw_pkg::t_in item);
            tccw_pkg::t_out res;
            logic [7:0]     g;
            int             addr;
            res = '0;
            case (item.cmd)
                tccw_pkg::CMD_PUT: begin
                    if (item.char_byte == tccw_pkg::CH_TAB) begin
                        store_at_cursor(cfg.blank_glyph, cfg.default_color);
                        cur_col += 2;
                    end else if (item.char_byte == tccw_pkg::CH_NEWLINE) begin
                        store_at_cursor(cfg.blank_glyph, cfg.default_color);
                        cur_row += 1;
                        cur_col = 0;
                        blink_ticks = '0;
                    end else begin
                        if (item.char_byte == tccw_pkg::CH_QUOTE) begin
                            quoted = !quoted;
                        end
                        g = item.char_byte;
                        if (!quoted && g >= tccw_pkg::CH_LOWER_A
                                && g <= tccw_pkg::CH_LOWER_Z) begin
                            g = g - tccw_pkg::CASE_OFFSET;
                        end
                        store_at_cursor(g, item.char_color);
                        cur_col += 1;
                    end
                    if (cur_col >= tccw_pkg::COLUMNS) begin
                        cur_col = tccw_pkg::COLUMNS - 1;
                    end
                    if (cur_row >= tccw_pkg::ROWS) begin
                        for (int i = 0; i < tccw_pkg::CELLS - tccw_pkg::COLUMNS; i++) begin
                            glyphs[i] = glyphs[i + tccw_pkg::COLUMNS];
                            colors[i] = colors[i + tccw_pkg::COLUMNS];
                        end
                        for (int i = tccw_pkg::CELLS - tccw_pkg::COLUMNS;
                             i < tccw_pkg::CELLS; i++) begin
                            glyphs[i] = cfg.blank_glyph;
                            colors[i] = '0;
                        end
                        cur_row = tccw_pkg::ROWS - 1;
                        res.scrolled = 1'b1;
                    end
                end
                tccw_pkg::CMD_SET: begin
                    cur_col = (int'(item.col_arg) < tccw_pkg::COLUMNS) ?
                              int'(item.col_arg) : tccw_pkg::COLUMNS - 1;
                    cur_row = (int'(item.row_arg) < tccw_pkg::ROWS) ?
                              int'(item.row_arg) : tccw_pkg::ROWS - 1;
                end
                tccw_pkg::CMD_CLEAR: begin
                    for (int i = 0; i < tccw_pkg::CELLS; i++) begin
                        glyphs[i] = cfg.blank_glyph;
                        colors[i] = '0;
                    end
                end
                tccw_pkg::CMD_BLINK: begin
                    store_at_cursor(blink_ticks[4] ? cfg.blank_glyph : cfg.cursor_glyph,
                                    cfg.default_color);
                    blink_ticks = blink_ticks + 8'd1;
                end
                tccw_pkg::CMD_READ: begin
                    if (int'(item.col_arg) < tccw_pkg::COLUMNS
                            && int'(item.row_arg) < tccw_pkg::ROWS) begin
                        addr = int'(item.row_arg) * tccw_pkg::COLUMNS + int'(item.col_arg);
                        res.read_glyph = glyphs[addr];
                        res.read_color = colors[addr];
                    end
                end
                default: ;
            endcase
            res.cursor_col_now = tccw_pkg::COL_FW'(cur_col);
            res.cursor_row_now = tccw_pkg::ROW_FW'(cur_row);
            due_results.push_back(res);
        endfunction

        function bit check_beat(tccw_pkg::t_out got, output string why);
            tccw_pkg::t_out want;
            why = "";
            if (due_results.size() == 0) begin
                why = "result beat with no command outstanding";
                return 1'b1;
            end
            want = due_results.pop_front();
            if (got.read_glyph !== want.read_glyph)
                why = {why, $sformatf(" read_glyph %h exp %h", got.read_glyph, want.read_glyph)};
            if (got.read_color !== want.read_color)
                why = {why, $sformatf(" read_color %h exp %h", got.read_color, want.read_color)};
            if (got.cursor_col_now !== want.cursor_col_now)
                why = {why, $sformatf(" col %0d exp %0d", got.cursor_col_now,
                                      want.cursor_col_now)};
            if (got.cursor_row_now !== want.cursor_row_now)
                why = {why, $sformatf(" row %0d exp %0d", got.cursor_row_now,
                                      want.cursor_row_now)};
            if (got.scrolled !== want.scrolled)
                why = {why, $sformatf(" scrolled %b exp %b", got.scrolled, want.scrolled)};
            return why != "";
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    tccw_pkg::t_in                   in_data;
    logic                            out_valid;
    logic                            out_ready;
    tccw_pkg::t_out                  out_data;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tccw_pkg::PADDR_W-1:0]    paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    console_grid_model    model;
    int                   errors;
    int                   beats;
    int unsigned          cycles;
    int                   sent;
    int                   heavy_used;
    bit                   in_burst;
    bit                   out_burst;
    string                why;

    text_console_char_writer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_LINES) begin
            $display("MISMATCH at beat %0d:%s", beats, msg);
        end
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (rst_n && out_valid && out_ready) begin
            if (model.check_beat(out_data, why)) begin
                report(why);
            end
            beats++;
        end
    end

    initial begin : result_side
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Called and returning at a falling edge.
    task automatic push_command(input tccw_pkg::t_in item);
        int gap;
        if (item.cmd == tccw_pkg::CMD_CLEAR ||
            (item.cmd == tccw_pkg::CMD_PUT && item.char_byte == tccw_pkg::CH_NEWLINE &&
             model.cur_row == tccw_pkg::ROWS - 1)) begin
            if (heavy_used >= HEAVY_MAX) begin
                item.cmd = tccw_pkg::CMD_READ;
            end else begin
                heavy_used++;
            end
        end
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        model.note_command(item);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (model.due_results.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tccw_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        model.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic tccw_pkg::t_in make_cmd(logic [2:0] c, logic [7:0] b,
                                               logic [31:0] color,
                                               logic [5:0] col, logic [4:0] row);
        tccw_pkg::t_in item;
        item.cmd        = c;
        item.char_byte  = b;
        item.char_color = color;
        item.col_arg    = col;
        item.row_arg    = row;
        return item;
    endfunction

    function automatic tccw_pkg::t_in rand_cmd(logic [2:0] c);
        logic [31:0] color;
        case ($urandom_range(0, 7))
            0:       color = '0;
            1:       color = '1;
            default: color = $urandom;
        endcase
        return make_cmd(c, 8'($urandom_range(0, 255)), color,
                        6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
    endfunction

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      return 8'($urandom_range(tccw_pkg::CH_LOWER_A,
                                                  tccw_pkg::CH_LOWER_Z));
        else if (r < 55) return 8'($urandom_range(8'h41, 8'h5A));
        else if (r < 62) return 8'($urandom_range(8'h30, 8'h39));
        else if (r < 70) return 8'h20;
        else if (r < 75) return tccw_pkg::CH_QUOTE;
        else if (r < 80) return tccw_pkg::CH_TAB;
        else if (r < 88) return tccw_pkg::CH_NEWLINE;
        else             return 8'($urandom_range(0, 255));
    endfunction

    initial begin : stimulus
        tccw_pkg::t_in item;
        int            target;
        int            n;
        logic [31:0]   cfg_color;
        logic [7:0]    cfg_blank;
        logic [7:0]    cfg_cursor;

        model      = new();
        errors     = 0;
        beats      = 0;
        cycles     = 0;
        sent       = 0;
        heavy_used = 0;
        in_burst   = 1'b0;
        out_burst  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_LOWER_A, 32'h1234_5678,
                              6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_QUOTE, 32'hFFFF_FFFF,
                              6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, 8'h62, 32'h0000_0001, 6'd63, 5'd31));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_LOWER_Z, 32'h8000_0000,
                              6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_QUOTE, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_LOWER_Z, 32'hA5A5_5A5A,
                              6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, 8'hFF, 32'hFFFF_FFFF, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd2, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd6, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_BLINK, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd0, 5'd1));
        push_command(make_cmd(tccw_pkg::CMD_SET, 8'h00, 32'h0, 6'd63, 5'd31));
        push_command(make_cmd(tccw_pkg::CMD_PUT, 8'h71, 32'h0BAD_F00D, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd63, 5'd30));
        push_command(make_cmd(3'd5, 8'hFF, 32'hFFFF_FFFF, 6'd63, 5'd31));
        push_command(make_cmd(3'd7, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_CLEAR, 8'h00, 32'h0, 6'd0, 5'd0));
        push_command(make_cmd(tccw_pkg::CMD_READ, 8'h00, 32'h0, 6'd63, 5'd31));

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: begin
                        cfg_color  = '0;
                        cfg_blank  = '0;
                        cfg_cursor = '0;
                    end
                    2: begin
                        cfg_color  = '1;
                        cfg_blank  = '1;
                        cfg_cursor = '1;
                    end
                    default: begin
                        cfg_color  = $urandom;
                        cfg_blank  = 8'($urandom_range(0, 255));
                        cfg_cursor = 8'($urandom_range(0, 255));
                    end
                endcase
                write_reg(tccw_pkg::REG_DEFAULT_COLOR, cfg_color);
                write_reg(tccw_pkg::REG_BLANK_GLYPH, {24'h0, cfg_blank});
                write_reg(tccw_pkg::REG_CURSOR_GLYPH, {24'h0, cfg_cursor});
            end
            target = sent + N_ITEMS / N_PHASES;
            while (sent < target) begin
                if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
                if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
                case ($urandom_range(0, 99)) inside
                    [0:44]: begin
                        n = $urandom_range(1, 30);
                        repeat (n) begin
                            item = rand_cmd(tccw_pkg::CMD_PUT);
                            item.char_byte = text_byte();
                            push_command(item);
                        end
                    end
                    [45:59]: begin
                        n = $urandom_range(1, 6);
                        repeat (n) begin
                            item = rand_cmd(tccw_pkg::CMD_READ);
                            if ($urandom_range(0, 1) == 1) begin
                                item.row_arg = tccw_pkg::ROW_FW'(model.cur_row);
                            end
                            push_command(item);
                        end
                    end
                    [60:69]: begin
                        n = $urandom_range(1, 40);
                        repeat (n) push_command(rand_cmd(tccw_pkg::CMD_BLINK));
                    end
                    [70:83]: begin
                        item = rand_cmd(tccw_pkg::CMD_SET);
                        if ($urandom_range(0, 3) == 0) begin
                            item.col_arg = tccw_pkg::COL_FW'(tccw_pkg::COLUMNS - 1);
                        end
                        if ($urandom_range(0, 2) == 0) begin
                            item.row_arg = tccw_pkg::ROW_FW'(tccw_pkg::ROWS - 1);
                        end
                        push_command(item);
                    end
                    [84:87]: push_command(rand_cmd(3'($urandom_range(5, 7))));
                    [88:89]: push_command(rand_cmd(tccw_pkg::CMD_CLEAR));
                    default: push_command(rand_cmd(3'($urandom_range(0, 7))));
                endcase
            end
        end

        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tccw_pkg.sv
rtl/tccw_cell_ram.sv
rtl/tccw_cfg_regs.sv
rtl/tccw_ctrl.sv
rtl/text_console_char_writer_core.sv
bench/tb_text_console_char_writer_core.sv
